[rtl/core/epa_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epa_pkg
// Shared types and constants of the deadline-ordered priority assigner.
// ---------------------------------------------------------------------------
package epa_pkg;

    localparam int SLOT_W     = 2;
    localparam int TIME_W     = 32;
    localparam int RUN_W      = 16;
    localparam int AVG_W      = 24;  // Q16.8
    localparam int PERIOD_W   = 16;
    localparam int PRIO_W     = 8;
    localparam int WEIGHT_W   = 9;   // Q1.8, 256 = one
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PERIOD_CNT = 4;
    localparam int SLOT_CNT   = 4;

    typedef logic [SLOT_W-1:0] t_slot;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_PRIO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 3'd5;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET [PERIOD_CNT] =
        '{16'd33, 16'd16, 16'd100, 16'd100};
    localparam logic [PRIO_W-1:0]   TOP_PRIO_RESET = 8'd8;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET   = 9'd77;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = 9'd256;

    // beat action codes
    localparam logic ACT_DONE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // cell operation codes
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_SORT   = 2'd1;
    localparam logic [1:0] OP_ROTATE = 2'd2;
    localparam logic [1:0] OP_UPDATE = 2'd3;

    // one rank position of the chain
    typedef struct packed {
        t_slot              slot;
        logic [TIME_W-1:0]  due;
        logic [AVG_W-1:0]   avg;
        logic [RUN_W-1:0]   est;
    } t_rec;

    // control broadcast to every cell
    typedef struct packed {
        logic [1:0]         op;
        logic               phase;
        t_slot              upd_slot;
        logic [TIME_W-1:0]  upd_due;
        logic [AVG_W-1:0]   upd_avg;
        logic [RUN_W-1:0]   upd_est;
    } t_cell_ctl;

endpackage

[rtl/core/epa_req_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epa_req_if
// Request channel: completion reports and scheduler ticks.
// ---------------------------------------------------------------------------
interface epa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [epa_pkg::SLOT_W-1:0]   task_index;
    logic [epa_pkg::RUN_W-1:0]    run_ticks;
    logic [epa_pkg::TIME_W-1:0]   release_time;
    logic [epa_pkg::TIME_W-1:0]   now_time;

    modport source (
        output valid, action, task_index, run_ticks, release_time, now_time,
        input  ready
    );
    modport sink (
        input  valid, action, task_index, run_ticks, release_time, now_time,
        output ready
    );
endinterface

[rtl/core/epa_res_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epa_res_if
// Result channel: one beat per rank after a tick.
// ---------------------------------------------------------------------------
interface epa_res_if;
    logic                         valid;
    logic                         ready;
    logic [epa_pkg::SLOT_W-1:0]   rank;
    logic [epa_pkg::SLOT_W-1:0]   slot;
    logic [epa_pkg::PRIO_W-1:0]   priority_res;
    logic [epa_pkg::TIME_W-1:0]   due_time;
    logic [epa_pkg::RUN_W-1:0]    estimate;
    logic                         missed;
    logic [epa_pkg::TIME_W-1:0]   overshoot;
    logic                         last;

    modport source (
        output valid, rank, slot, priority_res, due_time, estimate, missed,
               overshoot, last,
        input  ready
    );
    modport sink (
        input  valid, rank, slot, priority_res, due_time, estimate, missed,
               overshoot, last,
        output ready
    );
endinterface

[rtl/core/epa_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epa_cell
// One rank position: holds a slot record, compare-swaps with a neighbor.
// ---------------------------------------------------------------------------
module epa_cell #(
    parameter int IDX = 0,
    parameter int CNT = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  epa_pkg::t_cell_ctl i_ctl,
    input  epa_pkg::t_rec      i_left,
    input  epa_pkg::t_rec      i_right,
    output epa_pkg::t_rec      o_rec
);
    localparam bit   HAS_LEFT  = (IDX > 0);
    localparam bit   HAS_RIGHT = (IDX < CNT - 1);
    localparam logic PAR       = 1'(IDX % 2);

    epa_pkg::t_rec r_rec;
    epa_pkg::t_rec n_rec;

    always_comb begin
        n_rec = r_rec;
        case (i_ctl.op)
            epa_pkg::OP_SORT: begin
                // pair (k, k+1) with k of the current phase parity
                if (HAS_RIGHT && (i_ctl.phase == PAR)) begin
                    if (r_rec.due > i_right.due) begin
                        n_rec = i_right;
                    end
                end else if (HAS_LEFT && (i_ctl.phase != PAR)) begin
                    if (i_left.due > r_rec.due) begin
                        n_rec = i_left;
                    end
                end
            end
            epa_pkg::OP_ROTATE: begin
                n_rec = i_right;
            end
            epa_pkg::OP_UPDATE: begin
                if (r_rec.slot == i_ctl.upd_slot) begin
                    n_rec.due = i_ctl.upd_due;
                    n_rec.avg = i_ctl.upd_avg;
                    n_rec.est = i_ctl.upd_est;
                end
            end
            default: begin
                n_rec = r_rec;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec.slot <= epa_pkg::t_slot'(IDX);
            r_rec.due  <= '0;
            r_rec.avg  <= '0;
            r_rec.est  <= '0;
        end else begin
            r_rec <= n_rec;
        end
    end

    assign o_rec = r_rec;

endmodule

[rtl/core/edf_priority_assigner.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// edf_priority_assigner
// Earliest-deadline-first rank and priority assigner over a chain of cells.
// ---------------------------------------------------------------------------
//
//  channel  | dir | beat
//  ---------+-----+---------------------------------------------------------
//  i_req    | in  | completion report (slot, run time, release) or tick (now)
//  o_res    | out | one per rank after a tick: slot, priority, deadline, miss
//  i_cfg_*  | in  | register write: periods 0..3, top priority, weight
//
//  Completion: accepted, then select, multiply, sum and write back in turn.
//  No result beats.
//  Tick: accepted, then TASK_COUNT odd-even sort passes along the cell chain,
//  then TASK_COUNT result beats, one per cycle while o_res.ready stays high.
//  A stalled result holds the chain rotation; a new request is taken once
//  the last beat sits in the output register.
//  Reset is synchronous, active low; slots come up in order 0..TASK_COUNT-1.
//
module edf_priority_assigner #(
    parameter int TASK_COUNT = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    epa_req_if.sink                           i_req,
    epa_res_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [epa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [epa_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int              CNT_W    = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TASK_COUNT - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SEL  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_WR   = 3'd4;
    localparam logic [2:0] ST_SORT = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    // ---------------- configuration ----------------
    logic [epa_pkg::PERIOD_W-1:0] r_period [epa_pkg::PERIOD_CNT];
    logic [epa_pkg::PRIO_W-1:0]   r_top;
    logic [epa_pkg::WEIGHT_W-1:0] r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < epa_pkg::PERIOD_CNT; i++) begin
                r_period[i] <= epa_pkg::PERIOD_RESET[i];
            end
            r_top    <= epa_pkg::TOP_PRIO_RESET;
            r_weight <= epa_pkg::WEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx) inside
                [epa_pkg::REG_PERIOD0:epa_pkg::REG_PERIOD3]: begin
                    r_period[i_cfg_idx[epa_pkg::SLOT_W-1:0]] <= i_cfg_data;
                end
                epa_pkg::REG_TOP_PRIO: begin
                    r_top <= i_cfg_data[epa_pkg::PRIO_W-1:0];
                end
                epa_pkg::REG_WEIGHT: begin
                    r_weight <= i_cfg_data[epa_pkg::WEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // weight above one counts as one
    logic [epa_pkg::WEIGHT_W-1:0] w_wsat;
    logic [epa_pkg::WEIGHT_W-1:0] w_winv;
    assign w_wsat = (r_weight > epa_pkg::WEIGHT_ONE) ? epa_pkg::WEIGHT_ONE : r_weight;
    assign w_winv = epa_pkg::WEIGHT_ONE - w_wsat;

    // ---------------- control ----------------
    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_load;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    // next beat goes into the output register when it is free or draining
    assign w_load      = (r_state == ST_EMIT) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cnt   = '0;
                    n_state = (i_req.action == epa_pkg::ACT_TICK) ? ST_SORT : ST_SEL;
                end
            end
            ST_SEL:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_WR;
            ST_WR:   n_state = ST_IDLE;
            ST_SORT: begin
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    if (r_cnt == CNT_LAST) begin
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // ---------------- cell chain ----------------
    // Cell k holds rank k. Sorting swaps neighbor pairs with a strict compare,
    // which keeps ties in their earlier order. Emitting rotates the ring left
    // by one per beat, so after TASK_COUNT beats the order is back in place.
    epa_pkg::t_rec      w_rec [TASK_COUNT];
    epa_pkg::t_cell_ctl w_ctl;

    genvar g;
    generate
        for (g = 0; g < TASK_COUNT; g++) begin : g_cell
            epa_cell #(
                .IDX (g),
                .CNT (TASK_COUNT)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_left  (w_rec[(g + TASK_COUNT - 1) % TASK_COUNT]),
                .i_right (w_rec[(g + 1) % TASK_COUNT]),
                .o_rec   (w_rec[g])
            );
        end
    endgenerate

    // ---------------- moving average datapath ----------------
    epa_pkg::t_slot                  r_slot;
    logic [epa_pkg::RUN_W-1:0]       r_run;
    logic [epa_pkg::TIME_W-1:0]      r_rel;
    logic [epa_pkg::TIME_W-1:0]      r_now;
    logic [epa_pkg::AVG_W-1:0]       r_old_avg;
    logic [epa_pkg::TIME_W-1:0]      r_due;
    logic [24:0]                     r_p_new;   // w * run
    logic [32:0]                     r_p_old;   // (1 - w) * avg
    logic [epa_pkg::AVG_W-1:0]       r_avg;
    logic [epa_pkg::AVG_W-1:0]       w_sel_avg;
    logic [33:0]                     w_sum;
    logic [16:0]                     w_est_raw;
    logic [epa_pkg::RUN_W-1:0]       w_est;

    // old average of the reported slot; a slot with no cell reads zero
    // and is never written back
    always_comb begin
        w_sel_avg = '0;
        for (int i = 0; i < TASK_COUNT; i++) begin
            if (w_rec[i].slot == r_slot) begin
                w_sel_avg = w_sel_avg | w_rec[i].avg;
            end
        end
    end

    // w*(run<<8) + (1-w)*avg + 0.5 LSB, then back to Q16.8
    assign w_sum = 34'({r_p_new, 8'h00}) + 34'(r_p_old) + 34'd128;
    // ceiling to whole ticks, saturating
    assign w_est_raw = {1'b0, r_avg[23:8]} + 17'(r_avg[7:0] != 8'h00);
    assign w_est     = w_est_raw[16] ? '1 : w_est_raw[15:0];

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_slot <= i_req.task_index;
            r_run  <= i_req.run_ticks;
            r_rel  <= i_req.release_time;
            r_now  <= i_req.now_time;
        end
        if (r_state == ST_SEL) begin
            r_old_avg <= w_sel_avg;
            r_due     <= r_rel + 32'(r_period[r_slot]);
        end
        if (r_state == ST_MUL) begin
            r_p_new <= 25'(w_wsat) * 25'(r_run);
            r_p_old <= 33'(w_winv) * 33'(r_old_avg);
        end
        if (r_state == ST_SUM) begin
            r_avg <= w_sum[31:8];
        end
    end

    always_comb begin
        w_ctl          = '0;
        w_ctl.op       = epa_pkg::OP_HOLD;
        w_ctl.phase    = r_cnt[0];
        w_ctl.upd_slot = r_slot;
        w_ctl.upd_due  = r_due;
        w_ctl.upd_avg  = r_avg;
        w_ctl.upd_est  = w_est;
        case (r_state)
            ST_SORT: w_ctl.op = epa_pkg::OP_SORT;
            ST_WR:   w_ctl.op = epa_pkg::OP_UPDATE;
            ST_EMIT: w_ctl.op = w_load ? epa_pkg::OP_ROTATE : epa_pkg::OP_HOLD;
            default: w_ctl.op = epa_pkg::OP_HOLD;
        endcase
    end

    // ---------------- output register ----------------
    epa_pkg::t_slot               r_o_rank;
    epa_pkg::t_slot               r_o_slot;
    logic [epa_pkg::PRIO_W-1:0]   r_o_prio;
    logic [epa_pkg::TIME_W-1:0]   r_o_due;
    logic [epa_pkg::RUN_W-1:0]    r_o_est;
    logic                         r_o_miss;
    logic [epa_pkg::TIME_W-1:0]   r_o_over;
    logic                         r_o_last;
    logic [epa_pkg::PRIO_W-1:0]   w_rank_ext;
    logic                         w_miss;

    assign w_rank_ext = epa_pkg::PRIO_W'(r_cnt);
    assign w_miss     = (w_rec[0].due < r_now);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_rank <= epa_pkg::t_slot'(r_cnt);
            r_o_slot <= w_rec[0].slot;
            // priority floors at zero once rank passes the top value
            r_o_prio <= (r_top >= w_rank_ext) ? (r_top - w_rank_ext) : '0;
            r_o_due  <= w_rec[0].due;
            r_o_est  <= w_rec[0].est;
            r_o_miss <= w_miss;
            r_o_over <= w_miss ? (r_now - w_rec[0].due) : '0;
            r_o_last <= (r_cnt == CNT_LAST);
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.rank         = r_o_rank;
    assign o_res.slot         = r_o_slot;
    assign o_res.priority_res = r_o_prio;
    assign o_res.due_time     = r_o_due;
    assign o_res.estimate     = r_o_est;
    assign o_res.missed       = r_o_miss;
    assign o_res.overshoot    = r_o_over;
    assign o_res.last         = r_o_last;

    // ---------------- checks ----------------
    logic [epa_pkg::SLOT_CNT-1:0] w_slot_mask;
    logic                         w_sorted;

    always_comb begin
        w_slot_mask = '0;
        w_sorted    = 1'b1;
        for (int i = 0; i < TASK_COUNT; i++) begin
            w_slot_mask[w_rec[i].slot] = 1'b1;
        end
        for (int i = 0; i < TASK_COUNT - 1; i++) begin
            if (w_rec[i].due > w_rec[i + 1].due) begin
                w_sorted = 1'b0;
            end
        end
    end

    // chain always holds each slot exactly once
    a_slot_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_slot_mask) == TASK_COUNT)
        else $error("cell chain lost or duplicated a slot");

    // after the last sort pass the chain is in deadline order
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SORT && r_cnt == CNT_LAST) |=> w_sorted)
        else $error("chain not in deadline order after sort");

    // last flag marks the final rank only
    a_last_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |-> (o_res.rank == epa_pkg::t_slot'(CNT_LAST)))
        else $error("last beat carries wrong rank");

    // a completion never raises a result beat
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR) |=> !$rose(r_out_valid))
        else $error("result beat raised by completion");

endmodule

[sim/tb_edf_priority_assigner.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_edf_priority_assigner
// Self-checking bench for the deadline-ordered priority assigner. A short
// table of directed requests and register writes runs first, then random
// phases of completions and ticks under fresh register settings. Every tick
// is predicted rank by rank from a private copy of the slot state, and each
// result beat is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_edf_priority_assigner;

    // package widths and codes used throughout the bench
    localparam int SLOT_W     = epa_pkg::SLOT_W;
    localparam int TIME_W     = epa_pkg::TIME_W;
    localparam int RUN_W      = epa_pkg::RUN_W;
    localparam int AVG_W      = epa_pkg::AVG_W;
    localparam int PERIOD_W   = epa_pkg::PERIOD_W;
    localparam int PRIO_W     = epa_pkg::PRIO_W;
    localparam int WEIGHT_W   = epa_pkg::WEIGHT_W;
    localparam int CFG_IDX_W  = epa_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = epa_pkg::CFG_DATA_W;

    localparam logic ACT_DONE = epa_pkg::ACT_DONE;
    localparam logic ACT_TICK = epa_pkg::ACT_TICK;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD0  = epa_pkg::REG_PERIOD0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD3  = epa_pkg::REG_PERIOD3;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_PRIO = epa_pkg::REG_TOP_PRIO;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = epa_pkg::REG_WEIGHT;

    localparam logic [PRIO_W-1:0]   TOP_PRIO_RESET = epa_pkg::TOP_PRIO_RESET;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = epa_pkg::WEIGHT_ONE;

    localparam int TASKS           = 4;
    localparam int SETTLE_CYCLES   = 8;     // completion: accept + 4 stages
    localparam int QUIET_LIMIT     = 2000;  // cycles with no beat on any channel
    localparam int HOLD_CYCLES     = 300;   // long result back-pressure
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 18;
    localparam int CALM_PHASE      = 3;     // no idling on either side
    localparam int HOLD_PHASE      = 5;     // receiver stalls, input backs up
    localparam int PAUSE_PHASE     = 6;     // sender waits for a full drain

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD1 = REG_PERIOD0 + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD2 = REG_PERIOD0 + 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE6  = 3'd6;  // unmapped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE7  = 3'd7;  // unmapped

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] slot;
        logic [RUN_W-1:0]  run;
        logic [TIME_W-1:0] rel;
        logic [TIME_W-1:0] now;
    } t_req_beat;

    typedef struct packed {
        logic [SLOT_W-1:0] rank;
        logic [SLOT_W-1:0] slot;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] due;
        logic [RUN_W-1:0]  est;
        logic              missed;
        logic [TIME_W-1:0] over;
        logic              last;
    } t_rank_beat;

    // one directed step: a request, or a register write done while idle;
    // "typed" rows carry a hand-written rank 0 beat
    typedef struct packed {
        t_row_kind           kind;
        t_req_beat           req;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
        logic                typed;
        t_rank_beat          lead;
    } t_stim_row;

    localparam t_req_beat  NO_REQ  = '0;
    localparam t_rank_beat NO_LEAD = '0;
    localparam int DIR_ROWS_N = 33;

    localparam t_stim_row DIR_ROWS [DIR_ROWS_N] = '{
        // after reset: all deadlines zero, identity order, nothing missed
        '{ROW_REQ, '{ACT_TICK, 2'd0, 16'd0, 32'd0, 32'd0}, REG_PERIOD0, 16'd0, 1'b1,
          '{2'd0, 2'd0, TOP_PRIO_RESET, 32'd0, 16'd0, 1'b0, 32'd0, 1'b0}},
        // latest possible now: every slot missed by the full range
        '{ROW_REQ, '{ACT_TICK, 2'd3, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
          REG_PERIOD0, 16'd0, 1'b1,
          '{2'd0, 2'd0, TOP_PRIO_RESET, 32'd0, 16'd0, 1'b1, 32'hFFFF_FFFF, 1'b0}},
        // largest run time, release at the top so the deadline wraps
        '{ROW_REQ, '{ACT_DONE, 2'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
          REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_DONE, 2'd1, 16'd0, 32'd0, 32'd0}, REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_DONE, 2'd2, 16'd1, 32'h8000_0000, 32'd0},
          REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_DONE, 2'd3, 16'h5555, 32'h0000_0010, 32'h5555_AAAA},
          REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        // slot 0 due exactly now (not missed), slot 1 late
        '{ROW_REQ, '{ACT_TICK, 2'd0, 16'd0, 32'd0, 32'd32}, REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        // weight of exactly one: average jumps to the sample
        '{ROW_CFG, NO_REQ, REG_WEIGHT, 16'(WEIGHT_ONE), 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_DONE, 2'd3, 16'hFFFF, 32'd0, 32'd0}, REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        // weight zero: average holds
        '{ROW_CFG, NO_REQ, REG_WEIGHT, 16'd0, 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_DONE, 2'd3, 16'd1, 32'd5, 32'd0}, REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        // weight above one, all nine bits set: clamps to one
        '{ROW_CFG, NO_REQ, REG_WEIGHT, 16'h01FF, 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_DONE, 2'd2, 16'hAAAA, 32'hFFFF_FF00, 32'd0},
          REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        // upper data bits dropped, leaves 300
        '{ROW_CFG, NO_REQ, REG_WEIGHT, 16'hFF2C, 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_DONE, 2'd1, 16'd7, 32'h1234_5678, 32'd0},
          REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        // priority underflow: rank beyond top priority clips to zero
        '{ROW_CFG, NO_REQ, REG_TOP_PRIO, 16'd0, 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_TICK, 2'd0, 16'd0, 32'd0, 32'h8000_0000},
          REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        '{ROW_CFG, NO_REQ, REG_TOP_PRIO, 16'hFF01, 1'b0, NO_LEAD},
        // zero period: deadline equals release
        '{ROW_CFG, NO_REQ, REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_DONE, 2'd0, 16'd3, 32'd1000, 32'd0}, REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        '{ROW_CFG, NO_REQ, REG_PERIOD1, 16'hFFFF, 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_DONE, 2'd1, 16'd3, 32'hFFFF_FFFF, 32'd0},
          REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        // three slots tied at 1000: order must stay stable
        '{ROW_CFG, NO_REQ, REG_PERIOD2, 16'd16, 1'b0, NO_LEAD},
        '{ROW_CFG, NO_REQ, REG_PERIOD3, 16'd16, 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_DONE, 2'd2, 16'd9, 32'd984, 32'd0}, REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_DONE, 2'd3, 16'd9, 32'd984, 32'd0}, REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_TICK, 2'd1, 16'd0, 32'd0, 32'd1000}, REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        '{ROW_CFG, NO_REQ, REG_TOP_PRIO, 16'h00FF, 1'b0, NO_LEAD},
        // unmapped indexes must not disturb anything
        '{ROW_CFG, NO_REQ, REG_SPARE6, 16'hFFFF, 1'b0, NO_LEAD},
        '{ROW_CFG, NO_REQ, REG_SPARE7, 16'h1234, 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_TICK, 2'd2, 16'd0, 32'd0, 32'd999}, REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_DONE, 2'd0, 16'h8000, 32'hDEAD_BEEF, 32'd0},
          REG_PERIOD0, 16'd0, 1'b0, NO_LEAD},
        '{ROW_REQ, '{ACT_TICK, 2'd0, 16'd0, 32'd0, 32'hDEAD_BEEF},
          REG_PERIOD0, 16'd0, 1'b0, NO_LEAD}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    epa_req_if req_bus ();
    epa_res_if res_bus ();

    edf_priority_assigner #(
        .TASK_COUNT (TASKS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_res      (res_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // private copy of the slot state and registers
    logic [TIME_W-1:0]   slot_due   [TASKS];
    logic [AVG_W-1:0]    slot_avg   [TASKS];
    logic [RUN_W-1:0]    slot_est   [TASKS];
    logic [SLOT_W-1:0]   rank_order [TASKS];
    logic [PERIOD_W-1:0] reg_period [TASKS];
    logic [PRIO_W-1:0]   reg_top;
    logic [WEIGHT_W-1:0] reg_weight;

    t_rank_beat pending_ranks [$];
    int  fault_count   = 0;
    int  idle_pct      = 25;
    bit  hold_results  = 1'b0;
    int  quiet_cycles  = 0;

    // advance the slot state by one accepted request; a tick queues one
    // beat per rank
    task automatic apply_request(input t_req_beat r);
        logic [WEIGHT_W-1:0] w;
        logic [41:0]         acc;
        logic [AVG_W-1:0]    avg;
        logic [16:0]         ceil_run;
        logic [SLOT_W-1:0]   a, b;
        t_rank_beat          beat;
        if (r.action == ACT_DONE) begin
            w   = (reg_weight > WEIGHT_ONE) ? WEIGHT_ONE : reg_weight;
            acc = 42'(w) * (42'(r.run) << 8) + (42'd256 - 42'(w)) * 42'(slot_avg[r.slot]);
            avg = 24'((acc + 42'd128) >> 8);
            slot_avg[r.slot] = avg;
            ceil_run = 17'((25'(avg) + 25'd255) >> 8);
            slot_est[r.slot] = (ceil_run > 17'h0FFFF) ? 16'hFFFF : ceil_run[15:0];
            slot_due[r.slot] = r.rel + 32'(reg_period[r.slot]);
        end else begin
            // bubble pass keeps ties in their previous order
            for (int i = 0; i < TASKS - 1; i++) begin
                for (int j = 0; j < TASKS - 1 - i; j++) begin
                    a = rank_order[j];
                    b = rank_order[j + 1];
                    if (slot_due[a] > slot_due[b]) begin
                        rank_order[j]     = b;
                        rank_order[j + 1] = a;
                    end
                end
            end
            for (int k = 0; k < TASKS; k++) begin
                beat.rank   = SLOT_W'(k);
                beat.slot   = rank_order[k];
                beat.prio   = (32'(reg_top) >= k) ? PRIO_W'(32'(reg_top) - k) : '0;
                beat.due    = slot_due[beat.slot];
                beat.est    = slot_est[beat.slot];
                beat.missed = beat.due < r.now;
                beat.over   = beat.missed ? r.now - beat.due : '0;
                beat.last   = (k == TASKS - 1);
                pending_ranks.push_back(beat);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx <= REG_PERIOD3)
            reg_period[idx[SLOT_W-1:0]] = data;
        else if (idx == REG_TOP_PRIO)
            reg_top = data[PRIO_W-1:0];
        else if (idx == REG_WEIGHT)
            reg_weight = data[WEIGHT_W-1:0];
    endtask

    // offer one beat, with random gaps, and hold it until taken
    task automatic send_req(input t_req_beat r);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            req_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid        = 1'b1;
        req_bus.action       = r.action;
        req_bus.task_index   = r.slot;
        req_bus.run_ticks    = r.run;
        req_bus.release_time = r.rel;
        req_bus.now_time     = r.now;
        do @(posedge i_clk); while (!req_bus.ready);
        apply_request(r);
    endtask

    // stop offering, wait out every pending beat and the completion pipeline
    task automatic settle_block();
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        while (pending_ranks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int field_miss(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // result side: ready at the falling edge, random or held off
    initial begin
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                res_bus.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_results = 1'b0;
            end
            res_bus.ready = ($urandom_range(0, 99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin : res_check
        t_rank_beat got, want;
        int bad;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got = '{res_bus.rank, res_bus.slot, res_bus.priority_res, res_bus.due_time,
                    res_bus.estimate, res_bus.missed, res_bus.overshoot, res_bus.last};
            if (pending_ranks.size() == 0) begin
                $display("%0t ns: beat expected none, got rank %0d slot %0d due %0h",
                         $time, got.rank, got.slot, got.due);
                fault_count++;
            end else begin
                want = pending_ranks.pop_front();
                bad  = field_miss("rank", 32'(want.rank), 32'(got.rank))
                     + field_miss("slot", 32'(want.slot), 32'(got.slot))
                     + field_miss("priority", 32'(want.prio), 32'(got.prio))
                     + field_miss("due_time", want.due, got.due)
                     + field_miss("estimate", 32'(want.est), 32'(got.est))
                     + field_miss("missed", 32'(want.missed), 32'(got.missed))
                     + field_miss("overshoot", want.over, got.over)
                     + field_miss("last", 32'(want.last), 32'(got.last));
                if (bad != 0)
                    fault_count++;
            end
        end
    end

    // watchdog: any beat on either channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t ns: no beat for %0d cycles", $time, QUIET_LIMIT);
                $display("tb_edf_priority_assigner NOT OK");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_req_beat         r;
        logic [TIME_W-1:0] clock_base;
        logic [WEIGHT_W-1:0] w9;
        logic [PRIO_W-1:0] top8;

        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        req_bus.valid        = 1'b0;
        req_bus.action       = ACT_DONE;
        req_bus.task_index   = '0;
        req_bus.run_ticks    = '0;
        req_bus.release_time = '0;
        req_bus.now_time     = '0;

        for (int i = 0; i < TASKS; i++) begin
            slot_due[i]   = '0;
            slot_avg[i]   = '0;
            slot_est[i]   = '0;
            rank_order[i] = SLOT_W'(i);
            reg_period[i] = epa_pkg::PERIOD_RESET[i];
        end
        reg_top    = TOP_PRIO_RESET;
        reg_weight = epa_pkg::WEIGHT_RESET;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS_N; i++) begin
            if (DIR_ROWS[i].kind == ROW_CFG) begin
                settle_block();
                write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
            end else begin
                send_req(DIR_ROWS[i].req);
                // hand-written rank 0 beat stands in for the prediction
                if (DIR_ROWS[i].typed)
                    pending_ranks[pending_ranks.size() - TASKS] = DIR_ROWS[i].lead;
            end
        end

        // random phases, each under a fresh register setting
        clock_base = $urandom;
        for (int ph = 0; ph < PHASES; ph++) begin
            settle_block();
            for (int k = 0; k < TASKS; k++)
                write_reg(3'(REG_PERIOD0 + k), ($urandom_range(0, 7) == 0) ?
                          16'($urandom) : 16'($urandom_range(1, 200)));
            top8 = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 2))
                                               : 8'($urandom_range(3, 255));
            w9   = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                : 9'($urandom_range(0, 256));
            write_reg(REG_TOP_PRIO, {8'($urandom), top8});
            write_reg(REG_WEIGHT, {7'($urandom), w9});

            idle_pct = (ph == CALM_PHASE) ? 0 : 25;
            if (ph == HOLD_PHASE)
                hold_results = 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2)
                    settle_block();
                clock_base = clock_base + 32'($urandom_range(0, 50));
                if ($urandom_range(0, 7) == 0) begin
                    // noise: any field value at all
                    r.action = 1'($urandom);
                    r.slot   = 2'($urandom);
                    r.run    = 16'($urandom);
                    r.rel    = $urandom;
                    r.now    = $urandom;
                end else begin
                    // releases just behind, ticks just ahead of the running
                    // clock, so deadlines land on both sides of now
                    r.action = ($urandom_range(0, 1) == 0) ? ACT_DONE : ACT_TICK;
                    r.slot   = 2'($urandom);
                    r.run    = 16'($urandom_range(0, 3000));
                    r.rel    = clock_base - 32'($urandom_range(0, 100));
                    r.now    = clock_base + 32'($urandom_range(0, 150));
                end
                send_req(r);
            end
        end

        settle_block();
        if (fault_count == 0)
            $display("tb_edf_priority_assigner OK");
        else
            $display("tb_edf_priority_assigner NOT OK");
        $finish;
    end

endmodule
